>>> rtl/dfe_pkg.sv
// ----------------------------------------------------------------------------
// dfe_pkg
// Shared types and constants for the delimited field extractor: word
// layouts, configuration register indexes and the front-to-back command.
// ----------------------------------------------------------------------------
package dfe_pkg;

  // Field mask and its bit index
  localparam int MASK_W     = 64;
  localparam int MASK_IDX_W = 6;

  // Defaults for top-level parameters
  localparam int MAX_COLUMNS_DEFAULT = 64;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Line counter width
  localparam int LINE_CNT_W = 31;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINES  = 2'd2;

  // Character codes
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0] SPACE_BYTE   = 8'h20;

  // Register reset values
  localparam logic [7:0]            DELIMITER_RESET = 8'd9;
  localparam logic [LINE_CNT_W-1:0] MAX_LINES_RESET = 31'd30;

  // Input word
  typedef struct packed {
    logic [7:0] ch;
    logic       stream_end;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_word_t;

  // Configuration register set
  typedef struct packed {
    logic [7:0]            delimiter;
    logic [MASK_W-1:0]     field_mask;
    logic [LINE_CNT_W-1:0] max_lines;
  } cfg_t;

  // Command from front to back: optional leading space, then one byte
  typedef struct packed {
    logic       lead_space;
    logic [7:0] data;
  } cmd_t;

endpackage

>>> rtl/dfe_front.sv
// ----------------------------------------------------------------------------
// dfe_front
// Accepts input words, tracks the token/column/line state and turns each
// byte that produces output into one command for the back end.
// ----------------------------------------------------------------------------
module dfe_front #(
  parameter int MAX_COLUMNS = dfe_pkg::MAX_COLUMNS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  dfe_pkg::in_word_t in_data,
  output logic            in_stall,
  input  dfe_pkg::cfg_t   cfg,
  input  logic            q_full,
  output logic            push,
  output dfe_pkg::cmd_t   push_cmd
);

  localparam int COL_W = $clog2(MAX_COLUMNS + 1);

  logic [COL_W-1:0]               column_index, column_index_next;
  logic                           inside_token, inside_token_next;
  logic                           line_has_output, line_has_output_next;
  logic [dfe_pkg::LINE_CNT_W-1:0] lines_done, lines_done_next;

  logic accept;
  logic limit_hit;
  logic col_in_range;
  logic col_selected;
  logic is_delim;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Classification of the current byte
  assign limit_hit    = lines_done >= cfg.max_lines;
  assign col_in_range = column_index < COL_W'(MAX_COLUMNS);
  assign col_selected = col_in_range &&
                        cfg.field_mask[dfe_pkg::MASK_IDX_W'(column_index)];
  assign is_delim     = (cfg.delimiter != 8'd0) && (in_data.ch == cfg.delimiter);

  // Next state and command
  always_comb begin
    column_index_next    = column_index;
    inside_token_next    = inside_token;
    line_has_output_next = line_has_output;
    lines_done_next      = lines_done;
    push                 = 1'b0;
    push_cmd.lead_space  = 1'b0;
    push_cmd.data        = dfe_pkg::NEWLINE_BYTE;

    if (accept) begin
      if (in_data.stream_end) begin
        push                 = !limit_hit && line_has_output;
        column_index_next    = '0;
        inside_token_next    = 1'b0;
        line_has_output_next = 1'b0;
        lines_done_next      = '0;
      end else if (!limit_hit) begin
        if (in_data.ch == dfe_pkg::NEWLINE_BYTE) begin
          push                 = line_has_output;
          column_index_next    = '0;
          inside_token_next    = 1'b0;
          line_has_output_next = 1'b0;
          lines_done_next      = lines_done + 1'b1;
        end else if (is_delim) begin
          if (inside_token && col_in_range) begin
            column_index_next = column_index + 1'b1;
          end
          inside_token_next = 1'b0;
        end else begin
          if (col_selected) begin
            push                 = 1'b1;
            push_cmd.lead_space  = !inside_token && line_has_output;
            push_cmd.data        = in_data.ch;
            line_has_output_next = 1'b1;
          end
          inside_token_next = 1'b1;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      column_index    <= '0;
      inside_token    <= 1'b0;
      line_has_output <= 1'b0;
      lines_done      <= '0;
    end else begin
      column_index    <= column_index_next;
      inside_token    <= inside_token_next;
      line_has_output <= line_has_output_next;
      lines_done      <= lines_done_next;
    end
  end

endmodule

>>> rtl/dfe_queue.sv
// ----------------------------------------------------------------------------
// dfe_queue
// Small first-in first-out command queue between front and back end.
// Push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module dfe_queue #(
  parameter int WIDTH = 9,
  parameter int DEPTH = dfe_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = count == CNT_W'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/dfe_back.sv
// ----------------------------------------------------------------------------
// dfe_back
// Expands queued commands into output words: a command with a leading
// space gives a space word followed by the byte word, else the byte alone.
// ----------------------------------------------------------------------------
module dfe_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  dfe_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output dfe_pkg::out_word_t out_data
);

  logic       load;
  logic       pend;
  logic [7:0] pend_byte;

  // Output register is free when empty or being taken
  assign load  = !out_valid || !out_stall;
  assign q_pop = load && !pend && q_valid;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (load) begin
      if (pend) begin
        out_valid <= 1'b1;
        pend      <= 1'b0;
      end else if (q_valid) begin
        out_valid <= 1'b1;
        pend      <= q_cmd.lead_space;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (pend) begin
        out_data.out_byte <= pend_byte;
        out_data.out_last <= 1'b1;
      end else if (q_valid) begin
        pend_byte <= q_cmd.data;
        if (q_cmd.lead_space) begin
          out_data.out_byte <= dfe_pkg::SPACE_BYTE;
          out_data.out_last <= 1'b0;
        end else begin
          out_data.out_byte <= q_cmd.data;
          out_data.out_last <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/delimited_field_extractor_unit.sv
// ----------------------------------------------------------------------------
// delimited_field_extractor_unit
// Column selection on a newline-ended text stream, one byte per word.
// ----------------------------------------------------------------------------
// The block takes one input byte per cycle whenever in_stall is low; the
// front end classifies it and updates the line state in that same cycle.
// Bytes that produce output become commands in a QUEUE_DEPTH-entry queue,
// and the back end drives one output word per cycle, while out_stall is
// low, from a registered output stage, so a selected byte that opens a
// new token (space plus byte) gives two output words. The command for a
// byte is written into the queue, then its first word into the output
// register. A token start always follows a delimiter byte that makes no
// word, so the back end keeps up with input at full rate; in_stall rises
// only when the queue is full, which happens only when the output side is stalled.
module delimited_field_extractor_unit #(
  parameter int MAX_COLUMNS = dfe_pkg::MAX_COLUMNS_DEFAULT,
  parameter int QUEUE_DEPTH = dfe_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  dfe_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output dfe_pkg::out_word_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dfe_pkg::CFG_DATA_W-1:0] cfg_data
);

  dfe_pkg::cfg_t cfg;
  dfe_pkg::cmd_t push_cmd, q_cmd;
  logic          q_push, q_pop, q_full, q_valid;
  logic [$bits(dfe_pkg::cmd_t)-1:0] q_rd_data;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delimiter  <= dfe_pkg::DELIMITER_RESET;
      cfg.field_mask <= '0;
      cfg.max_lines  <= dfe_pkg::MAX_LINES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dfe_pkg::CFG_DELIMITER:  cfg.delimiter  <= cfg_data[7:0];
        dfe_pkg::CFG_FIELD_MASK: cfg.field_mask <= cfg_data[dfe_pkg::MASK_W-1:0];
        dfe_pkg::CFG_MAX_LINES:  cfg.max_lines  <= cfg_data[dfe_pkg::LINE_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: accept and classify
  dfe_front #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (q_push),
    .push_cmd (push_cmd)
  );

  // Command queue
  dfe_queue #(
    .WIDTH($bits(dfe_pkg::cmd_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .rd_valid  (q_valid),
    .rd_data   (q_rd_data)
  );

  assign q_cmd = dfe_pkg::cmd_t'(q_rd_data);

  // Back end: expand commands into output words
  dfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // Front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command pushed into full queue");

  // A space word taken is always followed by its byte word
  a_space_then_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !out_data.out_last) |=>
      (out_valid && out_data.out_last))
    else $error("space word not followed by its byte");

  // Only a space word is marked as not last
  a_space_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.out_last) |-> (out_data.out_byte == dfe_pkg::SPACE_BYTE))
    else $error("non-final word is not a space");
`endif

endmodule
